### src/maximum_gap_bucket_macros.svh
// -----------------------------------------------------------------------------
// Maximum gap bucket assertion macros
// Shared assertion forms for the maximum gap block.
// -----------------------------------------------------------------------------
`ifndef MAXIMUM_GAP_BUCKET_MACROS_SVH
`define MAXIMUM_GAP_BUCKET_MACROS_SVH

// implication checked on the same edge
`define MGB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked on the following edge
`define MGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/mgb_pkg.sv
// -----------------------------------------------------------------------------
// Maximum gap bucket package
// Sizes and helpers shared by the maximum gap block.
// -----------------------------------------------------------------------------
package mgb_pkg;
   localparam int MAX_ITEMS = 1024;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int BKT_W     = $clog2(MAX_ITEMS + 2);
   localparam int DATA_W    = 32;
   localparam int PROD_W    = DATA_W + CNT_W;

   typedef struct packed {
      logic             start;
      logic [PROD_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;
endpackage

### src/mgb_divider.sv
// -----------------------------------------------------------------------------
// Maximum gap bucket divider
// Restoring divider, one quotient bit a cycle.
// -----------------------------------------------------------------------------
module mgb_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  mgb_pkg::div_req_type          req,
   output logic                          done,
   output logic [mgb_pkg::PROD_W-1:0]    quotient
);
   localparam int STEP_W = $clog2(mgb_pkg::PROD_W + 1);

   logic [mgb_pkg::PROD_W-1:0] quot_ff, quot_in;
   logic [mgb_pkg::DATA_W:0]   rem_ff, rem_in;
   logic [mgb_pkg::DATA_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [mgb_pkg::DATA_W:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[mgb_pkg::DATA_W-1:0], quot_ff[mgb_pkg::PROD_W-1]};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         step_in = STEP_W'(mgb_pkg::PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[mgb_pkg::PROD_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[mgb_pkg::PROD_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule

### src/maximum_gap_bucket.sv
// -----------------------------------------------------------------------------
// Maximum gap bucket
// Largest sorted-neighbour gap of a loaded set, found by pigeonhole buckets.
// -----------------------------------------------------------------------------
// channel  ports                              transfer
// req      req_sample_value, req_last_item    start high, busy low
// rsp      rsp_largest_gap                    rsp_valid high, one cycle
//
// Loading takes one value a cycle. A marked item then starts a clearing sweep
// of n+1 flags, a bucket pass per value (serial divider plus memory
// read-modify-write) and a scan of n+1 buckets, unless under two values or
// all equal were loaded; busy stays high throughout. Reset is synchronous
// and needs no clearing pass. The receiver cannot stall.
`include "maximum_gap_bucket_macros.svh"

module maximum_gap_bucket (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic signed [31:0] req_sample_value,
   input  logic        req_last_item,
   output logic        rsp_valid,
   output logic [31:0] rsp_largest_gap
);
   localparam int IW = mgb_pkg::IDX_W;
   localparam int CW = mgb_pkg::CNT_W;
   localparam int BW = mgb_pkg::BKT_W;
   localparam int NB = mgb_pkg::MAX_ITEMS + 1;

   typedef enum logic [3:0] {
      S_LOAD, S_CLEAR, S_RDV, S_DIV, S_WAIT, S_RDB, S_UPD, S_SCAN_RD, S_SCAN, S_DONE
   } state_type;

   state_type state_ff;
   logic [CW-1:0]  count_ff;
   logic signed [31:0] min_ff, max_ff;
   logic [BW-1:0]  ptr_ff;
   logic [CW-1:0]  item_ff;
   logic signed [31:0] val_ff;
   logic [31:0]    best_ff, prev_ff;
   logic [BW-1:0]  bkt_ff;
   logic           rsp_valid_ff;
   logic [31:0]    rsp_gap_ff;

   logic signed [31:0] value_mem [mgb_pkg::MAX_ITEMS];
   logic signed [31:0] low_mem   [NB];
   logic signed [31:0] high_mem  [NB];
   logic               fill_mem  [NB];
   logic signed [31:0] vrd_ff, lrd_ff, hrd_ff;
   logic               frd_ff;

   mgb_pkg::div_req_type div_req;
   logic               div_done;
   logic [mgb_pkg::PROD_W-1:0] div_q;
   logic [31:0]        span, offs;
   logic [mgb_pkg::PROD_W-1:0] prod;

   assign span = 32'(max_ff) - 32'(min_ff);
   assign offs = 32'(vrd_ff) - 32'(min_ff);
   assign prod = mgb_pkg::PROD_W'(offs) * mgb_pkg::PROD_W'(count_ff);
   assign div_req.start    = (state_ff == S_DIV);
   assign div_req.dividend = prod;
   assign div_req.divisor  = span;

   mgb_divider u_div (
      .clock(clock), .reset(reset), .req(div_req), .done(div_done), .quotient(div_q)
   );

   logic accept;
   assign accept = start && !busy;
   assign busy   = (state_ff != S_LOAD);

   always_ff @(posedge clock) begin
      if (accept && count_ff < CW'(mgb_pkg::MAX_ITEMS))
         value_mem[count_ff[IW-1:0]] <= req_sample_value;
      vrd_ff <= value_mem[item_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR)
         fill_mem[ptr_ff] <= 1'b0;
      else if (state_ff == S_UPD)
         fill_mem[bkt_ff] <= 1'b1;
      frd_ff <= fill_mem[(state_ff == S_SCAN_RD || state_ff == S_SCAN) ? ptr_ff : bkt_ff];
   end

   logic signed [31:0] new_low, new_high;
   always_comb begin
      new_low  = (!frd_ff || val_ff < lrd_ff) ? val_ff : lrd_ff;
      new_high = (!frd_ff || val_ff > hrd_ff) ? val_ff : hrd_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_UPD) begin
         low_mem[bkt_ff]  <= new_low;
         high_mem[bkt_ff] <= new_high;
      end
      lrd_ff <= low_mem[(state_ff == S_SCAN_RD || state_ff == S_SCAN) ? ptr_ff : bkt_ff];
      hrd_ff <= high_mem[(state_ff == S_SCAN_RD || state_ff == S_SCAN) ? ptr_ff : bkt_ff];
   end

   logic [BW-1:0] last_bkt;
   assign last_bkt = BW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         min_ff       <= 32'sh7FFFFFFF;
         max_ff       <= 32'sh80000000;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         item_ff      <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  logic [CW-1:0] nc;
                  logic signed [31:0] nmin, nmax;
                  nc   = count_ff;
                  nmin = min_ff;
                  nmax = max_ff;
                  if (count_ff < CW'(mgb_pkg::MAX_ITEMS)) begin
                     nc = count_ff + 1'b1;
                     if (req_sample_value < min_ff) nmin = req_sample_value;
                     if (req_sample_value > max_ff) nmax = req_sample_value;
                  end
                  count_ff <= nc;
                  min_ff   <= nmin;
                  max_ff   <= nmax;
                  if (req_last_item) begin
                     ptr_ff  <= '0;
                     item_ff <= '0;
                     best_ff <= '0;
                     if (nc < CW'(2) || nmin == nmax) state_ff <= S_DONE;
                     else state_ff <= S_CLEAR;
                  end
               end
            end
            S_CLEAR: begin
               ptr_ff <= ptr_ff + 1'b1;
               if (ptr_ff == last_bkt) state_ff <= S_RDV;
            end
            S_RDV: state_ff <= S_DIV;
            S_DIV: begin
               val_ff   <= vrd_ff;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (div_done) begin
                  bkt_ff   <= (div_q > mgb_pkg::PROD_W'(mgb_pkg::MAX_ITEMS))
                              ? BW'(mgb_pkg::MAX_ITEMS) : BW'(div_q);
                  state_ff <= S_RDB;
               end
            end
            S_RDB: state_ff <= S_UPD;
            S_UPD: begin
               item_ff <= item_ff + 1'b1;
               if (item_ff + 1'b1 == count_ff) begin
                  ptr_ff   <= '0;
                  state_ff <= S_SCAN_RD;
               end else state_ff <= S_RDV;
            end
            S_SCAN_RD: begin
               ptr_ff   <= ptr_ff + 1'b1;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (ptr_ff == BW'(1)) prev_ff <= 32'(hrd_ff);
               else if (frd_ff) begin
                  if (32'(lrd_ff) - prev_ff > best_ff) best_ff <= 32'(lrd_ff) - prev_ff;
                  prev_ff <= 32'(hrd_ff);
               end
               if (ptr_ff == last_bkt + 1'b1) state_ff <= S_DONE;
               else ptr_ff <= ptr_ff + 1'b1;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_gap_ff   <= best_ff;
               count_ff     <= '0;
               min_ff       <= 32'sh7FFFFFFF;
               max_ff       <= 32'sh80000000;
               state_ff     <= S_LOAD;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_largest_gap = rsp_gap_ff;

   `MGB_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CW'(mgb_pkg::MAX_ITEMS))
   `MGB_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, state_ff == S_LOAD)
   `MGB_ASSERT_IMP(a_bkt_range, clock, reset, state_ff == S_UPD, bkt_ff <= last_bkt)
   `MGB_ASSERT_IMP(a_minmax, clock, reset, state_ff == S_CLEAR, min_ff < max_ff)
endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Maximum gap bucket testbench
// Loads sets of signed values through the command port and checks each
// largest-gap result against a bucket predictor kept in the bench. Directed
// sets cover the edge cases, then random sets with random idle bursts follow.
// -----------------------------------------------------------------------------
module testbench;
   typedef struct {
      logic signed [31:0] value;
      logic               last;
   } sample_type;

   localparam int WATCHDOG_LIMIT = 250000;
   localparam int TAIL_ITEMS     = 60;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_sample_value = '0;
   logic               req_last_item = 1'b0;
   logic               rsp_valid;
   logic [31:0]        rsp_largest_gap;

   sample_type         pending_samples[$];
   logic [31:0]        expected_gaps[$];
   logic signed [31:0] set_values[mgb_pkg::MAX_ITEMS];
   int                 set_len = 0;
   logic signed [31:0] set_min = 32'sh7fffffff;
   logic signed [31:0] set_max = 32'sh80000000;
   int                 idle_left = 0;
   int                 stall_cycles = 0;
   bit                 failed = 1'b0;

   maximum_gap_bucket dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample_value(req_sample_value), .req_last_item(req_last_item),
      .rsp_valid(rsp_valid), .rsp_largest_gap(rsp_largest_gap)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] largest_gap_of_set();
      logic signed [31:0] b_low[mgb_pkg::MAX_ITEMS+1];
      logic signed [31:0] b_high[mgb_pkg::MAX_ITEMS+1];
      bit                 b_full[mgb_pkg::MAX_ITEMS+1];
      longint unsigned    span, idx, n;
      logic [31:0]        best, prev_high, d, span32, off32;
      logic signed [31:0] v;
      n = set_len;
      if (set_len < 2 || set_min == set_max) return 32'd0;
      span32 = set_max - set_min;
      span = span32;
      for (int i = 0; i <= mgb_pkg::MAX_ITEMS; i++) b_full[i] = 1'b0;
      for (int i = 0; i < set_len; i++) begin
         v = set_values[i];
         off32 = v - set_min;
         idx = off32 * n / span;
         if (idx > mgb_pkg::MAX_ITEMS) idx = mgb_pkg::MAX_ITEMS;
         if (b_full[idx]) begin
            if (v < b_low[idx]) b_low[idx] = v;
            if (v > b_high[idx]) b_high[idx] = v;
         end else begin
            b_low[idx] = v;
            b_high[idx] = v;
            b_full[idx] = 1'b1;
         end
      end
      best = 0;
      prev_high = b_high[0];
      for (int i = 1; i <= set_len && i <= mgb_pkg::MAX_ITEMS; i++) begin
         if (b_full[i]) begin
            d = 32'(b_low[i]) - prev_high;
            if (d > best) best = d;
            prev_high = b_high[i];
         end
      end
      return best;
   endfunction

   task automatic load_sample(input logic signed [31:0] v, input logic last);
      if (set_len < mgb_pkg::MAX_ITEMS) begin
         set_values[set_len] = v;
         set_len++;
         if (v < set_min) set_min = v;
         if (v > set_max) set_max = v;
      end
      if (last) begin
         expected_gaps.push_back(largest_gap_of_set());
         set_len = 0;
         set_min = 32'sh7fffffff;
         set_max = 32'sh80000000;
      end
   endtask

   task automatic queue_set(input int len, input int mode);
      sample_type s;
      logic signed [31:0] base;
      base = $urandom;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: s.value = $urandom;
            1: s.value = base + $urandom_range(0, 7);
            2: s.value = base + $urandom_range(0, 100000);
            default: s.value = $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                                    : 32'sh80000000 + $urandom_range(0, 3);
         endcase
         s.last = (i == len - 1);
         pending_samples.push_back(s);
      end
   endtask

   task automatic queue_fixed(input logic signed [31:0] v, input logic last);
      sample_type s;
      s.value = v;
      s.last = last;
      pending_samples.push_back(s);
   endtask

   // driver: one transfer per edge with start high and busy low
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) load_sample(req_sample_value, req_last_item);
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_samples.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
            idle_left = $urandom_range(0, 11);
            start <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            req_sample_value <= pending_samples[0].value;
            req_last_item <= pending_samples[0].last;
            void'(pending_samples.pop_front());
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_gaps.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d", $time,
                     rsp_largest_gap);
            failed = 1'b1;
         end else begin
            if (rsp_largest_gap !== expected_gaps[0]) begin
               $display("%0t: largest_gap mismatch, expected %0d, actual %0d", $time,
                        expected_gaps[0], rsp_largest_gap);
               failed = 1'b1;
            end
            void'(expected_gaps.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      // directed sets
      queue_fixed(32'sd5, 1'b1);
      queue_fixed(32'sh80000000, 1'b0);
      queue_fixed(32'sh7fffffff, 1'b1);
      queue_fixed(32'sh7fffffff, 1'b0);
      queue_fixed(32'sh80000000, 1'b1);
      queue_fixed(-32'sd9, 1'b0);
      queue_fixed(-32'sd9, 1'b0);
      queue_fixed(-32'sd9, 1'b1);
      queue_fixed(32'sd1, 1'b0);
      queue_fixed(32'sd3, 1'b0);
      queue_fixed(32'sd10, 1'b0);
      queue_fixed(-32'sd4, 1'b1);
      queue_fixed(32'sd0, 1'b0);
      queue_fixed(32'shffffffff, 1'b0);
      queue_fixed(32'sh80000000, 1'b0);
      queue_fixed(32'sh7fffffff, 1'b0);
      queue_fixed(32'sh55555555, 1'b0);
      queue_fixed(32'shaaaaaaaa, 1'b1);
      queue_set(100, 0);
      for (int k = 0; k < 40; k++) queue_set($urandom_range(1, 14), $urandom_range(0, 3));
      for (int k = 0; k < 20; k++) queue_set($urandom_range(1, 8), $urandom_range(0, 3));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending_samples.size() == 0 && !start);
      wait (expected_gaps.size() == 0);
      repeat (200) @(posedge clock);
      if (!failed && expected_gaps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+src
src/mgb_pkg.sv
src/mgb_divider.sv
src/maximum_gap_bucket.sv
dv/testbench.sv
